[design/stick_navigation_autorepeat_assert.svh]
// assertion macros shared by the stick navigation auto-repeat modules
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef STICK_NAVIGATION_AUTOREPEAT_ASSERT_SVH
`define STICK_NAVIGATION_AUTOREPEAT_ASSERT_SVH
`ifndef SYNTHESIS
`define SNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sna assertion failed");
`define SNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sna assertion failed");
`else
`define SNA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SNA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/sna_pkg.sv]
// shared types, request codes, register indexes and helpers
// for the stick navigation auto-repeat block; no dependencies
package sna_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 3;

	typedef logic [1:0] op_t;
	localparam op_t OP_UPDATE = 2'd0;
	localparam op_t OP_TICK = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;
	localparam op_t OP_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT_MS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COS_SQ_LIMIT = 3'd4;

	localparam logic [9:0] RST_SETTLE_MS = 10'd16;
	localparam logic [11:0] RST_FIRST_REPEAT_MS = 12'd320;
	localparam logic [11:0] RST_REPEAT_MS = 12'd110;
	localparam logic [14:0] RST_DEADZONE = 15'd1;
	localparam logic [16:0] RST_COS_SQ_LIMIT = 17'd49152;

	typedef struct packed {
		op_t op;
		logic axis_is_x;
		logic signed [15:0] axis_value;
		logic [9:0] ms_passed;
	} item_t;

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		logic [15:0] r;
		r = v[15] ? 16'(-v) : 16'(v);
		return r;
	endfunction

endpackage

[design/sna_front.sv]
// input stage: accepts transactions, classifies them and pushes them to the queue
// depends on sna_pkg
module sna_front import sna_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic axis_is_x,
	input logic signed [15:0] axis_value,
	input logic [9:0] ms_passed,
	input logic q_full,
	output logic q_push,
	output item_t q_item
);

	logic stage_valid_q;
	item_t item_q;
	item_t item_c;

	always_comb begin
		item_c = '0;
		item_c.op = op_t'(req_type);
		unique case (req_type) inside
			OP_UPDATE: begin
				item_c.axis_is_x = axis_is_x;
				item_c.axis_value = axis_value;
			end
			OP_TICK: begin
				item_c.ms_passed = ms_passed;
			end
			OP_CLEAR, OP_NONE: begin
				item_c.op = op_t'(req_type);
			end
		endcase
	end

	assign q_push = stage_valid_q && !q_full;
	assign in_ready = !stage_valid_q || !q_full;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			stage_valid_q <= 1'b1;
		end else if (q_push) begin
			stage_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_c;
		end
	end

endmodule

[design/sna_fifo.sv]
// short queue between the input stage and the sequencer
// depends on sna_pkg and the assertion macro header
`include "stick_navigation_autorepeat_assert.svh"
module sna_fifo import sna_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t push_item,
	output logic full,
	input logic pop,
	output logic valid,
	output item_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`SNA_ASSERT_IMP(a_fifo_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))

endmodule

[design/sna_back.sv]
// sequencer: holds the stick and timer state, runs the angle test on a shared
// multiplier and drives the result register; depends on sna_pkg and the macro header
`include "stick_navigation_autorepeat_assert.svh"
module sna_back import sna_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic q_valid,
	input item_t q_head,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic fire,
	output logic active,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_CMP = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;
	localparam logic [3:0] LAST_STEP = 4'd10;

	logic [9:0] settle_ms_q;
	logic [11:0] first_repeat_ms_q;
	logic [11:0] repeat_ms_q;
	logic [14:0] deadzone_q;
	logic [16:0] cos_sq_limit_q;

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic signed [15:0] axis_x_q;
	logic signed [15:0] axis_y_q;
	logic signed [15:0] dir_x_q;
	logic signed [15:0] dir_y_q;
	logic active_q;
	logic [15:0] elapsed_q;
	logic settle_q;
	logic in_repeat_q;
	logic fire_q;

	logic out_valid_q;
	logic out_fire_q;
	logic out_active_q;
	logic signed [15:0] out_dir_x_q;
	logic signed [15:0] out_dir_y_q;

	logic [63:0] prod_q;
	logic psign_q;
	logic signed [32:0] dot_q;
	logic [31:0] na_q;
	logic [31:0] nb_q;
	logic [62:0] d2_q;
	logic [62:0] qprod_q;
	logic [48:0] rlo_q;
	logic [79:0] rhs_q;

	logic signed [15:0] new_x;
	logic signed [15:0] new_y;
	logic upd_live;
	logic [16:0] tick_sum;
	logic [15:0] tick_sat;
	logic [11:0] tick_th;
	logic settle_hit;
	logic rep_hit;
	logic tick_fire;
	logic need_angle;

	logic signed [15:0] x1e;
	logic signed [15:0] y1e;
	logic signed [15:0] x2e;
	logic signed [15:0] y2e;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic mul_sign;
	logic signed [32:0] pterm;
	logic [79:0] lhs;
	logic turned;
	logic out_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q <= RST_SETTLE_MS;
			first_repeat_ms_q <= RST_FIRST_REPEAT_MS;
			repeat_ms_q <= RST_REPEAT_MS;
			deadzone_q <= RST_DEADZONE;
			cos_sq_limit_q <= RST_COS_SQ_LIMIT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SETTLE_MS: settle_ms_q <= cfg_data[9:0];
				REG_FIRST_REPEAT_MS: first_repeat_ms_q <= cfg_data[11:0];
				REG_REPEAT_MS: repeat_ms_q <= cfg_data[11:0];
				REG_DEADZONE: deadzone_q <= cfg_data[14:0];
				REG_COS_SQ_LIMIT: cos_sq_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// axis update decode
	assign new_x = q_head.axis_is_x ? q_head.axis_value : axis_x_q;
	assign new_y = q_head.axis_is_x ? axis_y_q : q_head.axis_value;
	assign upd_live = (mag16(new_x) >= {1'b0, deadzone_q}) ||
		(mag16(new_y) >= {1'b0, deadzone_q});
	assign need_angle = (q_head.op == OP_UPDATE) && upd_live && active_q;

	// tick decode
	assign tick_sum = {1'b0, elapsed_q} + {7'd0, q_head.ms_passed};
	assign tick_sat = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
	assign tick_th = in_repeat_q ? repeat_ms_q : first_repeat_ms_q;
	assign settle_hit = tick_sat >= {6'd0, settle_ms_q};
	assign rep_hit = tick_sat >= {4'd0, tick_th};
	assign tick_fire = (q_head.op == OP_TICK) && active_q && (settle_q ? settle_hit : rep_hit);

	// zero vector points along +x
	assign x1e = (dir_x_q == '0 && dir_y_q == '0) ? 16'sd1 : dir_x_q;
	assign y1e = dir_y_q;
	assign x2e = (axis_x_q == '0 && axis_y_q == '0) ? 16'sd1 : axis_x_q;
	assign y2e = axis_y_q;

	// shared multiplier operand schedule
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_sign = 1'b0;
		case (step_q)
			4'd0: begin
				mul_a = {16'd0, mag16(x1e)};
				mul_b = {16'd0, mag16(x2e)};
				mul_sign = x1e[15] ^ x2e[15];
			end
			4'd1: begin
				mul_a = {16'd0, mag16(y1e)};
				mul_b = {16'd0, mag16(y2e)};
				mul_sign = y1e[15] ^ y2e[15];
			end
			4'd2: begin
				mul_a = {16'd0, mag16(x1e)};
				mul_b = {16'd0, mag16(x1e)};
			end
			4'd3: begin
				mul_a = {16'd0, mag16(y1e)};
				mul_b = {16'd0, mag16(y1e)};
			end
			4'd4: begin
				mul_a = {16'd0, mag16(x2e)};
				mul_b = {16'd0, mag16(x2e)};
			end
			4'd5: begin
				mul_a = {16'd0, mag16(y2e)};
				mul_b = {16'd0, mag16(y2e)};
			end
			4'd6: begin
				mul_a = dot_q[31:0];
				mul_b = dot_q[31:0];
			end
			4'd7: begin
				mul_a = na_q;
				mul_b = nb_q;
			end
			4'd8: begin
				mul_a = prod_q[31:0];
				mul_b = {15'd0, cos_sq_limit_q};
			end
			4'd9: begin
				mul_a = {1'b0, qprod_q[62:32]};
				mul_b = {15'd0, cos_sq_limit_q};
			end
			default: ;
		endcase
	end

	assign pterm = psign_q ? -$signed({1'b0, prod_q[31:0]}) : $signed({1'b0, prod_q[31:0]});
	assign lhs = {1'b0, d2_q, 16'd0};
	assign turned = dot_q[32] || (lhs < rhs_q);

	// angle test datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			psign_q <= mul_sign;
			case (step_q)
				4'd1: dot_q <= pterm;
				4'd2: dot_q <= dot_q + pterm;
				4'd3: na_q <= prod_q[31:0];
				4'd4: na_q <= na_q + prod_q[31:0];
				4'd5: nb_q <= prod_q[31:0];
				4'd6: nb_q <= nb_q + prod_q[31:0];
				4'd7: d2_q <= prod_q[62:0];
				4'd8: qprod_q <= prod_q[62:0];
				4'd9: rlo_q <= prod_q[48:0];
				4'd10: rhs_q <= {prod_q[47:0], 32'd0} + {31'd0, rlo_q};
				default: ;
			endcase
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// sequencer and stick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			axis_x_q <= '0;
			axis_y_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			active_q <= 1'b0;
			elapsed_q <= '0;
			settle_q <= 1'b0;
			in_repeat_q <= 1'b0;
			fire_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						fire_q <= tick_fire;
						state_q <= need_angle ? ST_MUL : ST_OUT;
						case (q_head.op)
							OP_UPDATE: begin
								axis_x_q <= new_x;
								axis_y_q <= new_y;
								if (!upd_live) begin
									active_q <= 1'b0;
									dir_x_q <= '0;
									dir_y_q <= '0;
									elapsed_q <= '0;
									settle_q <= 1'b0;
									in_repeat_q <= 1'b0;
								end else if (!active_q) begin
									active_q <= 1'b1;
									dir_x_q <= new_x;
									dir_y_q <= new_y;
									elapsed_q <= '0;
									settle_q <= 1'b1;
									in_repeat_q <= 1'b0;
								end else begin
									step_q <= '0;
								end
							end
							OP_TICK: begin
								if (active_q) begin
									if (settle_q) begin
										if (settle_hit) begin
											settle_q <= 1'b0;
											elapsed_q <= '0;
										end else begin
											elapsed_q <= tick_sat;
										end
									end else if (rep_hit) begin
										elapsed_q <= tick_sat - {4'd0, tick_th};
										in_repeat_q <= 1'b1;
									end else begin
										elapsed_q <= tick_sat;
									end
								end
							end
							OP_CLEAR: begin
								axis_x_q <= '0;
								axis_y_q <= '0;
								dir_x_q <= '0;
								dir_y_q <= '0;
								active_q <= 1'b0;
								elapsed_q <= '0;
								settle_q <= 1'b0;
								in_repeat_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (turned) begin
						elapsed_q <= '0;
						settle_q <= 1'b1;
						in_repeat_q <= 1'b0;
					end
					dir_x_q <= axis_x_q;
					dir_y_q <= axis_y_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fire_q <= fire_q;
			out_active_q <= active_q;
			out_dir_x_q <= dir_x_q;
			out_dir_y_q <= dir_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign fire = out_fire_q;
	assign active = out_active_q;
	assign dir_x = out_dir_x_q;
	assign dir_y = out_dir_y_q;

	`SNA_ASSERT_IMP(a_idle_state_clean, clk, arst_n, !active_q, dir_x_q == '0 && dir_y_q == '0 && elapsed_q == '0 && !settle_q && !in_repeat_q)
	`SNA_ASSERT_IMP(a_settle_excludes_repeat, clk, arst_n, settle_q, !in_repeat_q)
	`SNA_ASSERT_IMP(a_fire_needs_active, clk, arst_n, out_valid_q && out_fire_q, out_active_q)
	`SNA_ASSERT_NEXT(a_clear_zeroes, clk, arst_n, q_pop && q_head.op == OP_CLEAR, !active_q && elapsed_q == '0 && axis_x_q == '0 && axis_y_q == '0)

endmodule

[design/stick_navigation_autorepeat.sv]
// stick navigation auto-repeat, top level: input stage, queue and sequencer
// depends on sna_pkg, sna_front, sna_fifo and sna_back
// path: input stage register, queue, sequencer states IDLE and OUT, result register; an
// update that runs the angle test also passes states MUL and CMP; the angle test runs its
// 11 steps on the single shared 32x32 multiplier; the sequencer takes one transaction at
// a time and pops the next only when idle; reset clears state, loads register defaults
module stick_navigation_autorepeat import sna_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic axis_is_x,
	input logic signed [15:0] axis_value,
	input logic [9:0] ms_passed,
	output logic out_valid,
	input logic out_ready,
	output logic fire,
	output logic active,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	input logic cfg_wen,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	logic q_full;
	logic q_push;
	item_t q_item;
	logic q_valid;
	logic q_pop;
	item_t q_head;

	sna_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.axis_is_x(axis_is_x),
		.axis_value(axis_value),
		.ms_passed(ms_passed),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(q_item)
	);

	sna_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(q_item),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	sna_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fire(fire),
		.active(active),
		.dir_x(dir_x),
		.dir_y(dir_y)
	);

endmodule
